// File: design/key_short_long_press_detector_defines.svh
// Assertion macros shared by the press detector checker.
// Depends on nothing; included by the checker file.
`ifndef KEY_SHORT_LONG_PRESS_DETECTOR_DEFINES_SVH
`define KEY_SHORT_LONG_PRESS_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define KSLP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("press detector check failed");

// Next-cycle implication, disabled during reset
`define KSLP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("press detector check failed");

`endif

// File: design/kslp_pkg.sv
// Shared types and constants of the key short/long press detector.
// No dependencies.
`default_nettype none
package kslp_pkg;

  // Width of the debounce/held tick counter
  localparam int COUNT_BITS = 16;
  localparam int LONG_W     = 16;
  localparam int DEB_W      = 8;
  // Compare width covering the counter and both thresholds
  localparam int CMP_W      = (COUNT_BITS > LONG_W) ? COUNT_BITS : LONG_W;

  localparam int EVENT_W = 3;
  localparam logic [EVENT_W-1:0] EV_NONE = 3'd0;

  // Register map (index = paddr[2])
  localparam int ADDR_W = 3;
  localparam logic REG_LONG_PRESS = 1'b0;
  localparam logic REG_DEBOUNCE   = 1'b1;

  localparam logic [LONG_W-1:0] LONG_RESET = 16'd1000;
  localparam logic [DEB_W-1:0]  DEB_RESET  = 8'd10;

  typedef struct packed {
    logic [LONG_W-1:0] long_press_ticks;
    logic [DEB_W-1:0]  debounce_ticks;
  } cfg_t;

endpackage
`default_nettype wire

// File: design/kslp_fsm.sv
// Press detector state machine: debounce wait, key latch, held count.
// Depends on kslp_pkg.
`default_nettype none
module kslp_fsm
  import kslp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic               mode_key_level,
  input  wire logic               up_key_level,
  input  wire logic               down_key_level,
  input  wire cfg_t               cfg,
  output logic [EVENT_W-1:0]      key_event
);

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_DEBOUNCE = 2'd1;
  localparam logic [1:0] PH_HELD     = 2'd2;

  localparam logic [1:0] NO_KEY   = 2'd0;
  localparam logic [1:0] KEY_MODE = 2'd1;
  localparam logic [1:0] KEY_UP   = 2'd2;
  localparam logic [1:0] KEY_DOWN = 2'd3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [1:0]            phase, phase_next;
  logic [1:0]            held_key, held_key_next;
  logic [COUNT_BITS-1:0] tick_count, tick_count_next;

  logic                  any_down;
  logic [COUNT_BITS-1:0] count_inc;
  logic [1:0]            pick_key;

  assign any_down  = !mode_key_level || !up_key_level || !down_key_level;
  assign count_inc = (tick_count == COUNT_MAX) ? tick_count : tick_count + 1'b1;

  // Priority pick: mode, then up, then down
  always_comb begin
    if (!mode_key_level)      pick_key = KEY_MODE;
    else if (!up_key_level)   pick_key = KEY_UP;
    else if (!down_key_level) pick_key = KEY_DOWN;
    else                      pick_key = NO_KEY;
  end

  // Next state and event for one tick
  always_comb begin
    phase_next      = phase;
    held_key_next   = held_key;
    tick_count_next = tick_count;
    key_event       = EV_NONE;
    case (phase)
      PH_DEBOUNCE: begin
        tick_count_next = count_inc;
        if (CMP_W'(count_inc) >= CMP_W'(cfg.debounce_ticks)) begin
          tick_count_next = '0;
          if (pick_key != NO_KEY) begin
            held_key_next = pick_key;
            phase_next    = PH_HELD;
          end else begin
            phase_next = PH_IDLE;
          end
        end
      end
      PH_HELD: begin
        tick_count_next = count_inc;
        if (!any_down) begin
          if (held_key != NO_KEY) begin
            if (CMP_W'(count_inc) > CMP_W'(cfg.long_press_ticks))
              key_event = {held_key, 1'b0};
            else
              key_event = {held_key, 1'b0} - 1'b1;
          end
          phase_next      = PH_IDLE;
          tick_count_next = '0;
        end
      end
      default: begin
        // idle, and the unused code behaves as idle
        phase_next = PH_IDLE;
        if (any_down) begin
          tick_count_next = '0;
          if (cfg.debounce_ticks == '0) begin
            held_key_next = pick_key;
            phase_next    = PH_HELD;
          end else begin
            phase_next = PH_DEBOUNCE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      held_key   <= NO_KEY;
      tick_count <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      held_key   <= held_key_next;
      tick_count <= tick_count_next;
    end
  end

endmodule
`default_nettype wire

// File: design/kslp_skid.sv
// Two-entry output buffer for key events.
// Depends on kslp_pkg.
`default_nettype none
module kslp_skid
  import kslp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire logic [EVENT_W-1:0] push_data,
  output logic                    full,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [EVENT_W-1:0]      key_event
);

  logic [1:0]         count;
  logic [EVENT_W-1:0] head, spare;
  logic               pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign key_event = head;

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // Data slots: head is what the consumer sees
  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (count == 2'd2) begin
        head  <= spare;
        spare <= push_data;
      end else begin
        head <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) head <= push_data;
      else               spare <= push_data;
    end else if (pop) begin
      head <= spare;
    end
  end

endmodule
`default_nettype wire

// File: design/key_short_long_press_detector.sv
// Key short/long press detector: one millisecond tick per input transaction
// carrying the raw active-low levels of the mode, up and down keys; each tick
// yields exactly one key_event (0 none, odd short, even long, per key). A tick
// is taken every clock cycle unless stalled: the state update is a single
// compare and increment on the registered state, and a two-entry output buffer
// keeps the input open while a result waits. in_stall rises only when both
// entries are held. Registers: long_press_ticks at 0x0, debounce_ticks at 0x4.
// Depends on kslp_pkg, kslp_fsm, kslp_skid.
`default_nettype none
module key_short_long_press_detector
  import kslp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               mode_key_level,
  input  wire logic               up_key_level,
  input  wire logic               down_key_level,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [EVENT_W-1:0]      key_event,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  cfg_t               cfg;
  logic               accept;
  logic               full;
  logic               cfg_write;
  logic [EVENT_W-1:0] step_event;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign in_stall  = full;
  assign accept    = in_valid && !in_stall;

  // Configuration registers; low address bits are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_ticks <= LONG_RESET;
      cfg.debounce_ticks   <= DEB_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_LONG_PRESS) cfg.long_press_ticks <= pwdata[LONG_W-1:0];
      else                            cfg.debounce_ticks   <= pwdata[DEB_W-1:0];
    end
  end

  // Read back
  always_comb begin
    if (paddr[2] == REG_DEBOUNCE) prdata = {{(32-DEB_W){1'b0}}, cfg.debounce_ticks};
    else                          prdata = {{(32-LONG_W){1'b0}}, cfg.long_press_ticks};
  end

  kslp_fsm u_fsm (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .mode_key_level (mode_key_level),
    .up_key_level   (up_key_level),
    .down_key_level (down_key_level),
    .cfg            (cfg),
    .key_event      (step_event)
  );

  kslp_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (step_event),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .key_event (key_event)
  );

endmodule
`default_nettype wire

// File: design/kslp_checker.sv
// Port-level checks for the key press detector, bound to the top level.
// Depends on kslp_pkg and the shared assertion macros header.
`default_nettype none
`include "key_short_long_press_detector_defines.svh"
module kslp_checker
  import kslp_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [EVENT_W-1:0] key_event
);

  // A held result stays put
  `KSLP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(key_event))
  // An empty buffer never backpressures the input
  `KSLP_ASSERT_NOW(a_no_stall_empty, !out_valid, !in_stall)
  // Every accepted tick leaves a result pending
  `KSLP_ASSERT_NEXT(a_result_follows, in_valid && !in_stall, out_valid)
  // Event code 7 never appears
  `KSLP_ASSERT_NOW(a_event_range, out_valid, key_event != 3'd7)

endmodule

bind key_short_long_press_detector kslp_checker u_kslp_checker (.*);
`default_nettype wire
